// ===== rtl/sbc_pkg.sv =====
// Shared types, S-box tables and round functions for the Serpent cipher pipeline.
`default_nettype none
package sbc_pkg;

	typedef logic [3:0][31:0] blk_t;
	typedef logic [1:0] cmd_t;

	localparam cmd_t CMD_LOAD = 2'd0;
	localparam cmd_t CMD_ENC  = 2'd1;
	localparam cmd_t CMD_DEC  = 2'd2;

	localparam int NUM_KEYS = 33;
	localparam int NUM_RNDS = 32;

	localparam logic [3:0] SBOX [8][16] = '{
		'{4'd3, 4'd8, 4'd15, 4'd1, 4'd10, 4'd6, 4'd5, 4'd11,
		  4'd14, 4'd13, 4'd4, 4'd2, 4'd7, 4'd0, 4'd9, 4'd12},
		'{4'd15, 4'd12, 4'd2, 4'd7, 4'd9, 4'd0, 4'd5, 4'd10,
		  4'd1, 4'd11, 4'd14, 4'd8, 4'd6, 4'd13, 4'd3, 4'd4},
		'{4'd8, 4'd6, 4'd7, 4'd9, 4'd3, 4'd12, 4'd10, 4'd15,
		  4'd13, 4'd1, 4'd14, 4'd4, 4'd0, 4'd11, 4'd5, 4'd2},
		'{4'd0, 4'd15, 4'd11, 4'd8, 4'd12, 4'd9, 4'd6, 4'd3,
		  4'd13, 4'd1, 4'd2, 4'd4, 4'd10, 4'd7, 4'd5, 4'd14},
		'{4'd1, 4'd15, 4'd8, 4'd3, 4'd12, 4'd0, 4'd11, 4'd6,
		  4'd2, 4'd5, 4'd4, 4'd10, 4'd9, 4'd14, 4'd7, 4'd13},
		'{4'd15, 4'd5, 4'd2, 4'd11, 4'd4, 4'd10, 4'd9, 4'd12,
		  4'd0, 4'd3, 4'd14, 4'd8, 4'd13, 4'd6, 4'd7, 4'd1},
		'{4'd7, 4'd2, 4'd12, 4'd5, 4'd8, 4'd4, 4'd6, 4'd11,
		  4'd14, 4'd9, 4'd1, 4'd15, 4'd13, 4'd3, 4'd10, 4'd0},
		'{4'd1, 4'd13, 4'd15, 4'd0, 4'd14, 4'd8, 4'd2, 4'd11,
		  4'd7, 4'd4, 4'd12, 4'd10, 4'd9, 4'd3, 4'd5, 4'd6}
	};

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [3:0] inv_nib(input logic [2:0] box, input logic [3:0] v);
		logic [3:0] res;
		res = '0;
		for (int i = 0; i < 16; i++) begin
			if (SBOX[box][i] == v) res = 4'(i);
		end
		return res;
	endfunction

	// Bitsliced S-box: bit b of the four words forms one nibble.
	function automatic blk_t apply_box(input blk_t w, input logic [2:0] box,
		input logic inverse);
		blk_t r;
		logic [3:0] nib;
		logic [3:0] o;
		r = '0;
		for (int b = 0; b < 32; b++) begin
			nib = {w[3][b], w[2][b], w[1][b], w[0][b]};
			o = inverse ? inv_nib(box, nib) : SBOX[box][nib];
			for (int j = 0; j < 4; j++) r[j][b] = o[j];
		end
		return r;
	endfunction

	function automatic blk_t lin_fwd(input blk_t x);
		blk_t w;
		w = x;
		w[0] = rotl(w[0], 13);
		w[2] = rotl(w[2], 3);
		w[1] = w[1] ^ w[0] ^ w[2];
		w[3] = w[3] ^ w[2] ^ (w[0] << 3);
		w[1] = rotl(w[1], 1);
		w[3] = rotl(w[3], 7);
		w[0] = w[0] ^ w[1] ^ w[3];
		w[2] = w[2] ^ w[3] ^ (w[1] << 7);
		w[0] = rotl(w[0], 5);
		w[2] = rotl(w[2], 22);
		return w;
	endfunction

	function automatic blk_t lin_inv(input blk_t x);
		blk_t w;
		w = x;
		w[2] = rotl(w[2], 10);
		w[0] = rotl(w[0], 27);
		w[2] = w[2] ^ w[3] ^ (w[1] << 7);
		w[0] = w[0] ^ w[1] ^ w[3];
		w[3] = rotl(w[3], 25);
		w[1] = rotl(w[1], 31);
		w[3] = w[3] ^ w[2] ^ (w[0] << 3);
		w[1] = w[1] ^ w[0] ^ w[2];
		w[2] = rotl(w[2], 29);
		w[0] = rotl(w[0], 19);
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sbc_stage.sv =====
// One registered round stage, serving both encryption and decryption.
`default_nettype none
module sbc_stage import sbc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       adv,
	input  wire logic [4:0] idx,
	input  wire logic       v_in,
	input  wire logic       dec_in,
	input  wire logic       last_in,
	input  wire blk_t       w_in,
	input  wire blk_t       k_enc,
	input  wire blk_t       k_dec,
	input  wire blk_t       k_31,
	input  wire blk_t       k_32,
	output logic            v_out,
	output logic            dec_out,
	output logic            last_out,
	output blk_t            w_out
);

	localparam logic [4:0] IDX_LAST = 5'(NUM_RNDS - 1);

	blk_t enc_w;
	blk_t dec_w;
	logic [4:0] dec_rnd;

	always_comb begin
		// encryption: round idx, or the final round at the end
		if (idx == IDX_LAST) begin
			enc_w = apply_box(w_in ^ k_enc, 3'd7, 1'b0) ^ k_32;
		end else begin
			enc_w = lin_fwd(apply_box(w_in ^ k_enc, idx[2:0], 1'b0));
		end
		// decryption: undo the final round first, then rounds in reverse
		dec_rnd = IDX_LAST - idx;
		if (idx == 5'd0) begin
			dec_w = apply_box(w_in ^ k_32, 3'd7, 1'b1) ^ k_31;
		end else begin
			dec_w = apply_box(lin_inv(w_in), dec_rnd[2:0], 1'b1) ^ k_dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (adv) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_out  <= dec_in;
			last_out <= last_in;
			w_out    <= dec_in ? dec_w : enc_w;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/serpent_block_cipher.sv =====
// Top level of the pipelined Serpent ECB cipher with loadable subkeys.
// Usage:
//   Input channel (in_valid/in_stall) carries cmd, key_slot, word0..3 and
//   last_block. cmd load writes subkey key_slot (0..32) and gives no result;
//   encrypt and decrypt each give one result on the output channel
//   (out_valid/out_stall) with out_word0..3, was_decrypt and last_out.
//   Blocks flow through 32 unrolled round stages, one Serpent round per
//   stage; the last stage register is the output register. One block
//   enters every cycle unless the receiver stalls or a load waits.
//   A load is taken only when no block is in flight, so it waits for the
//   pipeline to drain; a block right after a load sees the new subkey.
//   cmd 3 and loads to slots above 32 are dropped.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_stall rises; nothing is lost or repeated.
//   Reset clears all stage valid bits; the subkey store is not cleared and
//   must be loaded before blocks are sent.
`default_nettype none
module serpent_block_cipher import sbc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [5:0]  key_slot,
	input  wire logic [31:0] word0,
	input  wire logic [31:0] word1,
	input  wire logic [31:0] word2,
	input  wire logic [31:0] word3,
	input  wire logic        last_block,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      out_word0,
	output logic [31:0]      out_word1,
	output logic [31:0]      out_word2,
	output logic [31:0]      out_word3,
	output logic             was_decrypt,
	output logic             last_out
);

	// subkey store: one 128-bit row per slot; rows 31 and 32 feed every stage
	blk_t key_q [NUM_KEYS];

	logic adv;
	logic pipe_busy;
	logic in_xfer;
	logic is_load;

	logic v_s    [NUM_RNDS+1];
	logic dec_s  [NUM_RNDS+1];
	logic last_s [NUM_RNDS+1];
	blk_t w_s    [NUM_RNDS+1];

	always_comb begin
		pipe_busy = 1'b0;
		for (int i = 1; i <= NUM_RNDS; i++) pipe_busy = pipe_busy | v_s[i];
	end

	// advance the whole pipe unless a finished result is held
	assign adv      = !out_valid || !out_stall;
	assign is_load  = (cmd == CMD_LOAD);
	assign in_stall = !adv || (is_load && pipe_busy);
	assign in_xfer  = in_valid && !in_stall;

	// stage 0 is the input side, not a register
	assign v_s[0]    = in_xfer && ((cmd == CMD_ENC) || (cmd == CMD_DEC));
	assign dec_s[0]  = (cmd == CMD_DEC);
	assign last_s[0] = last_block;
	assign w_s[0]    = {word3, word2, word1, word0};

	always_ff @(posedge clk) begin
		if (in_xfer && is_load && (key_slot < 6'(NUM_KEYS))) begin
			key_q[key_slot] <= {word3, word2, word1, word0};
		end
	end

	for (genvar g = 0; g < NUM_RNDS; g++) begin : g_rnd
		sbc_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.idx      (5'(g)),
			.v_in     (v_s[g]),
			.dec_in   (dec_s[g]),
			.last_in  (last_s[g]),
			.w_in     (w_s[g]),
			.k_enc    (key_q[g]),
			.k_dec    (key_q[NUM_RNDS - 1 - g]),
			.k_31     (key_q[NUM_RNDS - 1]),
			.k_32     (key_q[NUM_RNDS]),
			.v_out    (v_s[g+1]),
			.dec_out  (dec_s[g+1]),
			.last_out (last_s[g+1]),
			.w_out    (w_s[g+1])
		);
	end

	assign out_valid   = v_s[NUM_RNDS];
	assign was_decrypt = dec_s[NUM_RNDS];
	assign last_out    = last_s[NUM_RNDS];
	assign out_word0   = w_s[NUM_RNDS][0];
	assign out_word1   = w_s[NUM_RNDS][1];
	assign out_word2   = w_s[NUM_RNDS][2];
	assign out_word3   = w_s[NUM_RNDS][3];

endmodule
`default_nettype wire

// ===== dv/tb_serpent_block_cipher.sv =====
// Self-checking testbench for the Serpent ECB cipher: subkey loads, encrypt and decrypt blocks.
`default_nettype none
module tb_serpent_block_cipher;
	import sbc_pkg::*;

	// Local S-box copy for the predictor; the inverse is built from it at start.
	localparam logic [3:0] FWD_BOX [8][16] = '{
		'{4'd3, 4'd8, 4'd15, 4'd1, 4'd10, 4'd6, 4'd5, 4'd11,
		  4'd14, 4'd13, 4'd4, 4'd2, 4'd7, 4'd0, 4'd9, 4'd12},
		'{4'd15, 4'd12, 4'd2, 4'd7, 4'd9, 4'd0, 4'd5, 4'd10,
		  4'd1, 4'd11, 4'd14, 4'd8, 4'd6, 4'd13, 4'd3, 4'd4},
		'{4'd8, 4'd6, 4'd7, 4'd9, 4'd3, 4'd12, 4'd10, 4'd15,
		  4'd13, 4'd1, 4'd14, 4'd4, 4'd0, 4'd11, 4'd5, 4'd2},
		'{4'd0, 4'd15, 4'd11, 4'd8, 4'd12, 4'd9, 4'd6, 4'd3,
		  4'd13, 4'd1, 4'd2, 4'd4, 4'd10, 4'd7, 4'd5, 4'd14},
		'{4'd1, 4'd15, 4'd8, 4'd3, 4'd12, 4'd0, 4'd11, 4'd6,
		  4'd2, 4'd5, 4'd4, 4'd10, 4'd9, 4'd14, 4'd7, 4'd13},
		'{4'd15, 4'd5, 4'd2, 4'd11, 4'd4, 4'd10, 4'd9, 4'd12,
		  4'd0, 4'd3, 4'd14, 4'd8, 4'd13, 4'd6, 4'd7, 4'd1},
		'{4'd7, 4'd2, 4'd12, 4'd5, 4'd8, 4'd4, 4'd6, 4'd11,
		  4'd14, 4'd9, 4'd1, 4'd15, 4'd13, 4'd3, 4'd10, 4'd0},
		'{4'd1, 4'd13, 4'd15, 4'd0, 4'd14, 4'd8, 4'd2, 4'd11,
		  4'd7, 4'd4, 4'd12, 4'd10, 4'd9, 4'd3, 4'd5, 4'd6}
	};
	localparam logic [1:0] CMD_SPARE = 2'd3;

	typedef logic [3:0][31:0] words_t;
	typedef struct packed {
		words_t     data;
		logic       dec;
		logic       last;
	} cipher_res_t;
	typedef struct {
		cmd_t        op;
		logic [5:0]  slot;
		words_t      data;
		logic        last;
		logic        known;   // set when res holds an expected result
		words_t      res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = CMD_LOAD;
	logic [5:0] key_slot = '0;
	logic [31:0] word0 = '0, word1 = '0, word2 = '0, word3 = '0;
	logic last_block = 1'b0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic [31:0] out_word0, out_word1, out_word2, out_word3;
	logic was_decrypt, last_out;

	serpent_block_cipher u_top (.*);

	logic [31:0] key_mem [132];
	logic [3:0] inv_box [8][16];
	cipher_res_t pending_blocks [$];
	int errors = 0;
	bit busy_idle = 1'b1;   // when clear, neither side idles
	bit expect_known;
	words_t known_res;

	initial begin
		forever #6 clk = ~clk;
	end

	// Hard ceiling: ~1800 items plus pipeline fill, load drains and stalls.
	initial begin
		#(12 * 600000);
		$display("simulation failed");
		$finish;
	end

	function automatic logic [31:0] rol32(logic [31:0] v, int n);
		return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
	endfunction

	function automatic words_t sub_slice(words_t w, int box, bit back);
		words_t r;
		logic [3:0] nib, o;
		r = '0;
		for (int b = 0; b < 32; b++) begin
			nib = {w[3][b], w[2][b], w[1][b], w[0][b]};
			o = back ? inv_box[box][nib] : FWD_BOX[box][nib];
			for (int j = 0; j < 4; j++) r[j][b] = o[j];
		end
		return r;
	endfunction

	function automatic words_t add_subkey(words_t w, int k);
		for (int j = 0; j < 4; j++) w[j] ^= key_mem[4 * k + j];
		return w;
	endfunction

	function automatic words_t mix_fwd(words_t w);
		w[0] = rol32(w[0], 13);
		w[2] = rol32(w[2], 3);
		w[1] ^= w[0] ^ w[2];
		w[3] ^= w[2] ^ (w[0] << 3);
		w[1] = rol32(w[1], 1);
		w[3] = rol32(w[3], 7);
		w[0] ^= w[1] ^ w[3];
		w[2] ^= w[3] ^ (w[1] << 7);
		w[0] = rol32(w[0], 5);
		w[2] = rol32(w[2], 22);
		return w;
	endfunction

	function automatic words_t mix_back(words_t w);
		w[2] = rol32(w[2], 10);
		w[0] = rol32(w[0], 27);
		w[2] ^= w[3] ^ (w[1] << 7);
		w[0] ^= w[1] ^ w[3];
		w[3] = rol32(w[3], 25);
		w[1] = rol32(w[1], 31);
		w[3] ^= w[2] ^ (w[0] << 3);
		w[1] ^= w[0] ^ w[2];
		w[2] = rol32(w[2], 29);
		w[0] = rol32(w[0], 19);
		return w;
	endfunction

	function automatic words_t serpent_encrypt(words_t w);
		for (int r = 0; r < 31; r++) w = mix_fwd(sub_slice(add_subkey(w, r), r % 8, 0));
		return add_subkey(sub_slice(add_subkey(w, 31), 7, 0), 32);
	endfunction

	function automatic words_t serpent_decrypt(words_t w);
		w = add_subkey(sub_slice(add_subkey(w, 32), 7, 1), 31);
		for (int r = 31; r > 0; r--) w = add_subkey(sub_slice(mix_back(w), (r - 1) % 8, 1), r - 1);
		return w;
	endfunction

	// Advance the predictor by one accepted transfer; loads update the key store.
	task automatic predict_transfer(cmd_t op, logic [5:0] slot, words_t d, logic last);
		cipher_res_t e;
		if (op == CMD_LOAD) begin
			if (slot < NUM_KEYS)
				for (int j = 0; j < 4; j++) key_mem[4 * slot + j] = d[j];
		end else if (op == CMD_ENC || op == CMD_DEC) begin
			e.data = (op == CMD_ENC) ? serpent_encrypt(d) : serpent_decrypt(d);
			e.dec = (op == CMD_DEC);
			e.last = last;
			if (expect_known && e.data != known_res) begin
				$display("%0t predictor vs table: expected %h actual %h", $time, known_res, e.data);
				errors++;
			end
			pending_blocks.push_back(e);
		end
	endtask

	// Hold one transfer on the input until it is taken; idle gaps at random first.
	task automatic send_item(cmd_t op, logic [5:0] slot, words_t d, logic last);
		while (busy_idle && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		key_slot <= slot;
		{word3, word2, word1, word0} <= d;
		last_block <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_transfer(op, slot, d, last);
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Key schedules load only after the pipeline drains so the block stream is not stalled mid-flight
	// by the testbench itself; the block handles overlap, but order is kept simple here.
	task automatic drain();
		end_burst();
		while (pending_blocks.size() != 0) @(posedge clk);
		repeat (34) @(posedge clk);
	endtask

	task automatic load_random_keys();
		words_t d;
		for (int k = 0; k < NUM_KEYS; k++) begin
			d = {$urandom, $urandom, $urandom, $urandom};
			send_item(CMD_LOAD, 6'(k), d, 1'($urandom));
		end
	endtask

	// Receiver: stall at random, check each transfer against the oldest expectation.
	always @(posedge clk) begin
		cipher_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_blocks.size() == 0) begin
				$display("%0t unexpected result: expected none actual %h %h %h %h", $time,
					out_word3, out_word2, out_word1, out_word0);
				errors++;
			end else begin
				e = pending_blocks.pop_front();
				if ({out_word3, out_word2, out_word1, out_word0} != e.data) begin
					$display("%0t data mismatch: expected %h actual %h", $time, e.data,
						{out_word3, out_word2, out_word1, out_word0});
					errors++;
				end
				if (was_decrypt !== e.dec) begin
					$display("%0t was_decrypt: expected %b actual %b", $time, e.dec, was_decrypt);
					errors++;
				end
				if (last_out !== e.last) begin
					$display("%0t last_out: expected %b actual %b", $time, e.last, last_out);
					errors++;
				end
			end
		end
		out_stall <= busy_idle ? ($urandom_range(99) < 35) : 1'b0;
	end

	stim_row_t dir_rows [$];

	initial begin
		stim_row_t row;
		words_t d;
		int op_pick;
		for (int b = 0; b < 8; b++)
			for (int i = 0; i < 16; i++) inv_box[b][FWD_BOX[b][i]] = 4'(i);
		for (int i = 0; i < 132; i++) key_mem[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All-zero subkeys: every round key is zero, so the blocks below see only the S-boxes
		// and the linear transform, and each result is checked against the predictor.
		for (int k = 0; k < NUM_KEYS; k++) send_item(CMD_LOAD, 6'(k), '0, 1'b0);
		// Out-of-range slots and the spare command must be dropped.
		send_item(CMD_LOAD, 6'd33, {4{32'hFFFF_FFFF}}, 1'b1);
		send_item(CMD_LOAD, 6'd63, {4{32'hFFFF_FFFF}}, 1'b0);
		send_item(CMD_SPARE, 6'd0, {4{32'hFFFF_FFFF}}, 1'b1);
		drain();
		// Directed table: extremes of the data words, both operations, both marks.
		dir_rows = '{
			'{CMD_ENC, 6'd0, '0, 1'b0, 1'b0, '0},
			'{CMD_DEC, 6'd0, '0, 1'b1, 1'b0, '0},
			'{CMD_ENC, 6'd0, {4{32'hFFFF_FFFF}}, 1'b1, 1'b0, '0},
			'{CMD_DEC, 6'd0, {4{32'hFFFF_FFFF}}, 1'b0, 1'b0, '0},
			'{CMD_ENC, 6'd0, {32'h8000_0000, 32'h0, 32'h0, 32'h1}, 1'b0, 1'b0, '0},
			'{CMD_DEC, 6'd0, {32'h1, 32'h0, 32'h0, 32'h8000_0000}, 1'b1, 1'b0, '0},
			'{CMD_ENC, 6'd0, {32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h5A5A_5A5A},
				1'b0, 1'b0, '0}
		};
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			expect_known = row.known;
			known_res = row.res;
			send_item(row.op, row.slot, row.data, row.last);
		end
		expect_known = 1'b0;
		// Extreme subkeys: all ones, with one encrypt and one decrypt.
		drain();
		for (int k = 0; k < NUM_KEYS; k++) send_item(CMD_LOAD, 6'(k), {4{32'hFFFF_FFFF}}, 1'b1);
		send_item(CMD_ENC, 6'd0, '0, 1'b1);
		send_item(CMD_DEC, 6'd0, {4{32'hFFFF_FFFF}}, 1'b0);

		// Random phases: fresh key schedule, then a burst of blocks with a few
		// stray commands; one phase runs with no idling at all.
		for (int ph = 0; ph < 10; ph++) begin
			drain();
			busy_idle = (ph != 5);
			load_random_keys();
			for (int n = 0; n < 140; n++) begin
				op_pick = $urandom_range(99);
				d = {$urandom, $urandom, $urandom, $urandom};
				if (op_pick < 3)
					send_item(CMD_SPARE, 6'($urandom), d, 1'($urandom));
				else if (op_pick < 6)
					send_item(CMD_LOAD, 6'($urandom_range(63, 33)), d, 1'($urandom));
				else if (op_pick < 9)
					// Reload a slot mid-stream with fresh words.
					send_item(CMD_LOAD, 6'($urandom_range(32)), d, 1'($urandom));
				else
					send_item((op_pick & 1) ? CMD_ENC : CMD_DEC, 6'($urandom), d,
						1'($urandom));
			end
		end
		busy_idle = 1'b1;
		end_burst();
		while (pending_blocks.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
